@@ sv/stepper_step_ramp_generator_assert.svh @@
// assertion macros for the step ramp generator
`ifndef STEPPER_STEP_RAMP_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_RAMP_GENERATOR_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SSRG_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ssrg invariant violated");

// consequence in the same cycle
`define SSRG_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssrg implication violated");

// consequence in the next cycle
`define SSRG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssrg sequence violated");

`endif

@@ sv/ssrg_pkg.sv @@
// shared types, codes and reset constants of the step ramp generator
package ssrg_pkg;

    typedef logic [1:0]  action_t;
    typedef logic [2:0]  cfg_idx_t;
    typedef logic [15:0] period_t;
    typedef logic [31:0] count_t;

    // item actions
    localparam action_t ACT_TICK  = 2'd0;
    localparam action_t ACT_START = 2'd1;
    localparam action_t ACT_CHAIN = 2'd2;
    localparam action_t ACT_SET   = 2'd3;

    // configuration register indexes
    localparam cfg_idx_t REG_MIN_PERIOD     = 3'd0;
    localparam cfg_idx_t REG_MAX_PERIOD     = 3'd1;
    localparam cfg_idx_t REG_RAMP_BASE      = 3'd2;
    localparam cfg_idx_t REG_RAMP_DELTA_REF = 3'd3;
    localparam cfg_idx_t REG_RAMP_MAX       = 3'd4;
    localparam cfg_idx_t REG_CHAIN_MAX      = 3'd5;

    // configuration reset values
    localparam period_t MIN_PERIOD_RST  = 16'd100;
    localparam period_t MAX_PERIOD_RST  = 16'd65535;
    localparam period_t RAMP_BASE_RST   = 16'd64;
    localparam period_t DELTA_REF_RST   = 16'd1000;
    localparam period_t RAMP_MAX_RST    = 16'd1024;
    localparam period_t CHAIN_MAX_RST   = 16'd256;

    // shortest ramp of a plain start
    localparam count_t MIN_START_RAMP = 32'd16;

    // serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // ceiling first, then floor
    function automatic period_t clamp_period(period_t p, period_t lo, period_t hi);
        period_t r;
        if (p > hi)
        begin
            r = hi;
        end
        else if (p < lo)
        begin
            r = lo;
        end
        else
        begin
            r = p;
        end
        return r;
    endfunction

endpackage

@@ sv/stepper_step_ramp_generator.sv @@
// step and direction generator with a linear period ramp
//
// Step and direction generator for a stepper driver. Every input transfer is
// one item: a timer compare tick, a start, a chain or a direct period write,
// and each item gives exactly one result transfer with the pin levels, the
// timer half period, the position, the steps left, the running flag and a
// move-done strobe. A start or chain picks a linear ramp from the current
// period to the clamped target; its length scales with the period change and
// is capped by the ramp registers and the move length. Items are handled one
// at a time and in_ready is low while an item is in work. A tick that
// advances the ramp and a start or chain whose length is scaled both go
// through one shared 32-step restoring divider: S_EVAL, S_DIV, S_QUOT, then
// S_LEN for a start or chain, and S_OUT. A start or chain whose length needs
// no division skips S_DIV and S_QUOT; any other item goes from S_EVAL to
// S_OUT. A finished result waits in the output register while the next
// item is taken; the block stalls only when that result is still untaken as
// the next one completes. Configuration writes are always accepted
// (cfg_ready is tied high) and must only arrive while the block is idle.
`include "stepper_step_ramp_generator_assert.svh"

module stepper_step_ramp_generator (
    input  logic              clk,
    input  logic              rst_n,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  ssrg_pkg::cfg_idx_t cfg_index,
    input  logic [15:0]       cfg_data,
    // item channel
    input  logic              in_valid,
    output logic              in_ready,
    input  ssrg_pkg::action_t action,
    input  logic              move_dir,
    input  logic [15:0]       target_period,
    input  logic [31:0]       move_count,
    input  logic              limit_up,
    input  logic              limit_down,
    // result channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              step_level,
    output logic              dir_level,
    output logic [15:0]       timer_half_period,
    output logic signed [31:0] position,
    output logic [31:0]       steps_remaining,
    output logic              running,
    output logic              move_done
);
    import ssrg_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_QUOT = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // what the divider result feeds
    localparam logic DIV_ADV = 1'b0;
    localparam logic DIV_LEN = 1'b1;

    // configuration registers
    period_t min_period_reg;
    period_t max_period_reg;
    period_t ramp_base_reg;
    period_t delta_ref_reg;
    period_t ramp_max_reg;
    period_t chain_max_reg;

    // sequencer
    logic [2:0] state_reg, state_next;

    // captured item
    action_t act_reg;
    logic    mdir_reg;
    period_t target_reg;
    count_t  count_reg;
    logic    lim_up_reg;
    logic    lim_down_reg;

    // motion state
    logic        step_high_reg, step_high_next;
    logic        running_reg, running_next;
    logic        direction_reg, direction_next;
    count_t      steps_left_reg, steps_left_next;
    logic [31:0] position_reg, position_next;
    period_t     ramp_from_reg, ramp_from_next;
    period_t     ramp_to_reg, ramp_to_next;
    period_t     ramp_len_reg, ramp_len_next;
    period_t     ramp_rem_reg, ramp_rem_next;
    period_t     period_reg, period_next;
    logic        done_reg, done_next;
    count_t      len_reg, len_next;

    // shared divider
    logic [31:0]          div_dvd_reg, div_dvd_next;
    logic [15:0]          div_rem_reg, div_rem_next;
    logic [15:0]          div_dsr_reg, div_dsr_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 div_kind_reg, div_kind_next;

    // output register
    logic        out_valid_reg, out_valid_next;
    logic        out_step_reg;
    logic        out_dir_reg;
    period_t     out_period_reg;
    logic [31:0] out_pos_reg;
    count_t      out_steps_reg;
    logic        out_run_reg;
    logic        out_done_reg;

    // datapath helpers
    logic        in_xfer;
    logic        load_out;
    logic        limit_hit;
    count_t      steps_eff;
    count_t      steps_dec;
    period_t     rr_dec;
    logic        ramp_up;
    period_t     ramp_mag;
    period_t     ramp_done;
    period_t     tgt_clamped;
    period_t     ramp_start;
    period_t     new_delta;
    period_t     mul_a;
    period_t     mul_b;
    logic [31:0] product;
    count_t      len_c1;
    count_t      len_c2;
    count_t      len_c3;
    count_t      len_c4;
    logic        chained;
    logic [16:0] div_shift;
    logic [16:0] div_diff;
    logic        div_ge;
    period_t     quot;
    period_t     adv_period;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    // tick: limit switch for the direction of travel
    assign limit_hit = direction_reg ? lim_down_reg : lim_up_reg;
    assign steps_eff = limit_hit ? '0 : steps_left_reg;
    assign steps_dec = steps_eff - 32'd1;

    // ramp interpolation operands
    assign rr_dec    = ramp_rem_reg - 16'd1;
    assign ramp_up   = (ramp_to_reg >= ramp_from_reg);
    assign ramp_mag  = ramp_up ? (ramp_to_reg - ramp_from_reg) : (ramp_from_reg - ramp_to_reg);
    assign ramp_done = ramp_len_reg - rr_dec;

    // new ramp end points
    assign tgt_clamped = clamp_period(target_reg, min_period_reg, max_period_reg);
    assign ramp_start  = (period_reg < min_period_reg) ? min_period_reg : period_reg;
    assign new_delta   = (ramp_start >= tgt_clamped) ? (ramp_start - tgt_clamped)
                                                     : (tgt_clamped - ramp_start);

    // one multiplier, shared by ramp steps and ramp length scaling
    assign mul_a   = (act_reg == ACT_TICK) ? ramp_mag : new_delta;
    assign mul_b   = (act_reg == ACT_TICK) ? ramp_done : ramp_base_reg;
    assign product = {16'd0, mul_a} * {16'd0, mul_b};

    // ramp length caps, in the order the move rules apply them
    assign chained = (act_reg == ACT_CHAIN);
    assign len_c1  = (len_reg > {16'd0, ramp_max_reg}) ? {16'd0, ramp_max_reg} : len_reg;
    assign len_c2  = (len_c1 > count_reg) ? count_reg : len_c1;
    assign len_c3  = (!chained && (len_c2 < MIN_START_RAMP) && (count_reg >= MIN_START_RAMP))
                     ? MIN_START_RAMP : len_c2;
    assign len_c4  = (chained && (len_c3 > {16'd0, chain_max_reg}))
                     ? {16'd0, chain_max_reg} : len_c3;

    // restoring division step
    assign div_shift = {div_rem_reg, div_dvd_reg[31]};
    assign div_ge    = (div_shift >= {1'b0, div_dsr_reg});
    assign div_diff  = div_shift - {1'b0, div_dsr_reg};

    // quotient is below the ramp span, so 16 bits hold it
    assign quot       = div_dvd_reg[15:0];
    assign adv_period = ramp_up ? (ramp_from_reg + quot) : (ramp_from_reg - quot);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            ramp_base_reg  <= RAMP_BASE_RST;
            delta_ref_reg  <= DELTA_REF_RST;
            ramp_max_reg   <= RAMP_MAX_RST;
            chain_max_reg  <= CHAIN_MAX_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MIN_PERIOD:     min_period_reg <= cfg_data;
                REG_MAX_PERIOD:     max_period_reg <= cfg_data;
                REG_RAMP_BASE:      ramp_base_reg  <= cfg_data;
                REG_RAMP_DELTA_REF: delta_ref_reg  <= cfg_data;
                REG_RAMP_MAX:       ramp_max_reg   <= cfg_data;
                REG_CHAIN_MAX:      chain_max_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // item capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg      <= action;
            mdir_reg     <= move_dir;
            target_reg   <= target_period;
            count_reg    <= move_count;
            lim_up_reg   <= limit_up;
            lim_down_reg <= limit_down;
        end
    end

    // sequencer and motion state update
    always_comb
    begin
        state_next     = state_reg;
        step_high_next = step_high_reg;
        running_next   = running_reg;
        direction_next = direction_reg;
        steps_left_next = steps_left_reg;
        position_next  = position_reg;
        ramp_from_next = ramp_from_reg;
        ramp_to_next   = ramp_to_reg;
        ramp_len_next  = ramp_len_reg;
        ramp_rem_next  = ramp_rem_reg;
        period_next    = period_reg;
        done_next      = done_reg;
        len_next       = len_reg;
        div_dvd_next   = div_dvd_reg;
        div_rem_next   = div_rem_reg;
        div_dsr_next   = div_dsr_reg;
        div_cnt_next   = div_cnt_reg;
        div_kind_next  = div_kind_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    done_next  = 1'b0;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_OUT;
                unique case (act_reg) inside
                    ACT_TICK:
                    begin
                        if (running_reg)
                        begin
                            if (step_high_reg)
                            begin
                                step_high_next = 1'b0;
                            end
                            else if (steps_eff == '0)
                            begin
                                // limit hit or nothing left: end of move
                                steps_left_next = '0;
                                running_next    = 1'b0;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                step_high_next  = 1'b1;
                                steps_left_next = steps_dec;
                                position_next   = direction_reg ? (position_reg - 32'd1)
                                                                : (position_reg + 32'd1);
                                if (steps_dec == '0)
                                begin
                                    running_next = 1'b0;
                                    done_next    = 1'b1;
                                end
                                if (ramp_rem_reg != '0)
                                begin
                                    if ((rr_dec == '0) || (ramp_len_reg == '0))
                                    begin
                                        // last ramp step lands exactly on the target
                                        ramp_rem_next = '0;
                                        period_next   = ramp_to_reg;
                                    end
                                    else
                                    begin
                                        ramp_rem_next = rr_dec;
                                        div_dvd_next  = product;
                                        div_rem_next  = '0;
                                        div_dsr_next  = ramp_len_reg;
                                        div_cnt_next  = '0;
                                        div_kind_next = DIV_ADV;
                                        state_next    = S_DIV;
                                    end
                                end
                            end
                        end
                    end

                    ACT_START,
                    ACT_CHAIN:
                    begin
                        if (count_reg == '0)
                        begin
                            // zero-length start stops, zero-length chain is ignored
                            if (!chained)
                            begin
                                steps_left_next = '0;
                                running_next    = 1'b0;
                            end
                        end
                        else
                        begin
                            direction_next  = mdir_reg;
                            steps_left_next = count_reg;
                            running_next    = 1'b1;
                            ramp_from_next  = ramp_start;
                            ramp_to_next    = tgt_clamped;
                            if (ramp_start == tgt_clamped)
                            begin
                                ramp_len_next = '0;
                                ramp_rem_next = '0;
                                period_next   = tgt_clamped;
                            end
                            else if (new_delta > delta_ref_reg)
                            begin
                                if (delta_ref_reg == '0)
                                begin
                                    len_next   = {16'd0, ramp_max_reg};
                                    state_next = S_LEN;
                                end
                                else
                                begin
                                    // length scales with the period change
                                    div_dvd_next  = product;
                                    div_rem_next  = '0;
                                    div_dsr_next  = delta_ref_reg;
                                    div_cnt_next  = '0;
                                    div_kind_next = DIV_LEN;
                                    state_next    = S_DIV;
                                end
                            end
                            else
                            begin
                                len_next   = {16'd0, ramp_base_reg};
                                state_next = S_LEN;
                            end
                        end
                    end

                    ACT_SET:
                    begin
                        period_next   = tgt_clamped;
                        ramp_rem_next = '0;
                    end

                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_DIV:
            begin
                div_rem_next = div_ge ? div_diff[15:0] : div_shift[15:0];
                div_dvd_next = {div_dvd_reg[30:0], div_ge};
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_QUOT;
                end
            end

            S_QUOT:
            begin
                if (div_kind_reg == DIV_ADV)
                begin
                    period_next = clamp_period(adv_period, min_period_reg, max_period_reg);
                    state_next  = S_OUT;
                end
                else
                begin
                    len_next   = div_dvd_reg;
                    state_next = S_LEN;
                end
            end

            S_LEN:
            begin
                if (len_c4 == '0)
                begin
                    ramp_len_next = '0;
                    ramp_rem_next = '0;
                    period_next   = ramp_to_reg;
                end
                else
                begin
                    ramp_len_next = len_c4[15:0];
                    ramp_rem_next = len_c4[15:0];
                    period_next   = ramp_from_reg;
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                // hold here while the previous result is still untaken
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_high_reg  <= 1'b0;
            running_reg    <= 1'b0;
            direction_reg  <= 1'b0;
            steps_left_reg <= '0;
            position_reg   <= '0;
            ramp_from_reg  <= '0;
            ramp_to_reg    <= '0;
            ramp_len_reg   <= '0;
            ramp_rem_reg   <= '0;
            period_reg     <= MIN_PERIOD_RST;
            done_reg       <= 1'b0;
            div_cnt_reg    <= '0;
            div_kind_reg   <= DIV_ADV;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_high_reg  <= step_high_next;
            running_reg    <= running_next;
            direction_reg  <= direction_next;
            steps_left_reg <= steps_left_next;
            position_reg   <= position_next;
            ramp_from_reg  <= ramp_from_next;
            ramp_to_reg    <= ramp_to_next;
            ramp_len_reg   <= ramp_len_next;
            ramp_rem_reg   <= ramp_rem_next;
            period_reg     <= period_next;
            done_reg       <= done_next;
            div_cnt_reg    <= div_cnt_next;
            div_kind_reg   <= div_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // divider and length datapath, no reset needed
    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        div_dvd_reg <= div_dvd_next;
        div_rem_reg <= div_rem_next;
        div_dsr_reg <= div_dsr_next;
    end

    // result register, loaded from the committed state
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_step_reg   <= step_high_reg;
            out_dir_reg    <= direction_reg;
            out_period_reg <= period_reg;
            out_pos_reg    <= position_reg;
            out_steps_reg  <= steps_left_reg;
            out_run_reg    <= running_reg;
            out_done_reg   <= done_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign step_level        = out_step_reg;
    assign dir_level         = out_dir_reg;
    assign timer_half_period = out_period_reg;
    assign position          = $signed(out_pos_reg);
    assign steps_remaining   = out_steps_reg;
    assign running           = out_run_reg;
    assign move_done         = out_done_reg;

    // checks
    `SSRG_ASSERT_ALWAYS(a_rem_within_len, ramp_rem_reg <= ramp_len_reg)
    `SSRG_ASSERT_IMPLIES(a_stopped_no_steps, !running_reg, steps_left_reg == '0)
    `SSRG_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready)
    `SSRG_ASSERT_IMPLIES(a_div_nonzero, state_reg == S_DIV, div_dsr_reg != '0)

endmodule
